// File: rtl/scakf_pkg.sv
// ----------------------------------------------------------------------------
// scakf_pkg
// Shared types, codes and helpers of the scalar angle Kalman filter core.
// ----------------------------------------------------------------------------
package scakf_pkg;

	// working width for angles, errors and sums of the datapath
	typedef logic signed [35:0] wide_t;

	// step kind codes
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_SEEDED   = 3'd0;
	localparam kind_t KIND_PREDICT  = 3'd1;
	localparam kind_t KIND_FUSED    = 3'd2;
	localparam kind_t KIND_BLENDED  = 3'd3;
	localparam kind_t KIND_TAKEOVER = 3'd4;
	localparam kind_t KIND_RESET    = 3'd5;

	// configuration register indexes
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_PROCESS_NOISE = 3'd0;
	localparam reg_idx_t REG_MEASURE_NOISE = 3'd1;
	localparam reg_idx_t REG_SAMPLE_PERIOD = 3'd2;
	localparam reg_idx_t REG_CHI_THRESHOLD = 3'd3;
	localparam reg_idx_t REG_ADAPTIVE_MODE = 3'd4;

	// reset values of the registers
	localparam logic [31:0] RST_MEASURE_NOISE = 32'd6711;
	localparam logic [23:0] RST_SAMPLE_PERIOD = 24'd33554;
	localparam logic [15:0] RST_CHI_THRESHOLD = 16'd983;

	localparam logic [31:0] ONE_Q24 = 32'd16777216;
	localparam wide_t DEG180 = 36'sd11796480;
	// 360 degrees in Q16.16 scaled by 2^10, first subtrahend of the wrap reduction
	localparam logic [35:0] DEG360_TOP = 36'd24159191040;
	localparam wide_t S32_MAX = 36'sd2147483647;
	localparam wide_t S32_MIN = -36'sd2147483648;

	// wrap unit modes
	typedef logic [1:0] wrap_mode_t;
	localparam wrap_mode_t WRAP_PASS = 2'd0;
	localparam wrap_mode_t WRAP_HIGH = 2'd1;
	localparam wrap_mode_t WRAP_LOW  = 2'd2;

	// iteration counts of the serial units
	localparam logic [5:0] MUL_STEPS  = 6'd32;
	localparam logic [5:0] DIV_STEPS  = 6'd24;
	localparam logic [5:0] WRAP_STEPS = 6'd11;

	function automatic logic signed [31:0] sat32(input wide_t v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// divide by 2^24 rounding half up on a magnitude
	function automatic logic [41:0] rnd24(input logic [65:0] p);
		logic [65:0] s;
		s = p + 66'd8388608;
		return s[65:24];
	endfunction

	// apply a sign to a rounded magnitude
	function automatic wide_t neg_if(input logic neg, input logic [41:0] mag);
		wide_t m;
		m = {1'b0, mag[34:0]};
		return neg ? -m : m;
	endfunction

endpackage

// File: rtl/scalar_angle_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar_angle_kalman_filter_core
// One-state Kalman filter for an angle with a bit-serial datapath.
// ----------------------------------------------------------------------------
// usage
//   input words arrive on item_valid / item_stall: an update (req_type 0)
//   carrying a measured angle and a rate, or a reset (req_type 1) that
//   reseeds the angle. each input word gives exactly one result word on
//   result_valid / result_stall: estimate, variance and step kind.
//   registers are written through cfg_we / cfg_index / cfg_data while idle.
// datapath
//   one word is worked at a time. a shared shift-add multiplier works each
//   product as a load, 32 bit steps and a finish, a restoring divider
//   takes 24 quotient bits and a wrap reducer 11 steps; the sequencer adds
//   its decide, gate and done states. the next word is taken in the cycle
//   after the result is handed over.
// reset
//   arst_n clears the estimate to zero, variance to 1.0, seeded flag and the
//   registers to their defaults; no result is pending after reset.
// stall
//   a finished result sits in the output register until taken; the next word
//   is accepted meanwhile, and its result waits in the done state.
// ----------------------------------------------------------------------------
module scalar_angle_kalman_filter_core (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	// input words
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                req_type,
	input  logic signed [24:0]  angle_value,
	input  logic                angle_valid,
	input  logic signed [27:0]  rate_value,
	input  logic                rate_valid,
	// result words
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [31:0]  angle_estimate,
	output logic [31:0]         variance_estimate,
	output logic [2:0]          step_kind
);

	// sequencer states
	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_DU       = 5'd1;
	localparam logic [4:0] ST_DECIDE   = 5'd2;
	localparam logic [4:0] ST_RST_WRAP = 5'd3;
	localparam logic [4:0] ST_PRD_WRAP = 5'd4;
	localparam logic [4:0] ST_WRAP_X   = 5'd5;
	localparam logic [4:0] ST_GAIN     = 5'd6;
	localparam logic [4:0] ST_WRAP_E   = 5'd7;
	localparam logic [4:0] ST_KE       = 5'd8;
	localparam logic [4:0] ST_WRAP_F   = 5'd9;
	localparam logic [4:0] ST_M2       = 5'd10;
	localparam logic [4:0] ST_CHI      = 5'd11;
	localparam logic [4:0] ST_GATE     = 5'd12;
	localparam logic [4:0] ST_RATIO    = 5'd13;
	localparam logic [4:0] ST_RD       = 5'd14;
	localparam logic [4:0] ST_SHRINK   = 5'd15;
	localparam logic [4:0] ST_DONE     = 5'd16;

	logic [4:0] state_q;

	// configuration registers
	logic [31:0] pnoise_q;
	logic [31:0] mnoise_q;
	logic [23:0] dt_q;
	logic [15:0] chi_q;
	logic        adaptive_q;

	// filter state
	logic signed [31:0] est_x_q;
	logic [31:0]        est_p_q;
	logic               seeded_q;

	// captured input word
	logic               req_q;
	logic               zv_q;
	logic               uv_q;
	logic signed [24:0] z_q;
	logic signed [27:0] u_q;

	// working registers of one update
	scakf_pkg::wide_t du_q;
	scakf_pkg::wide_t xp_q;
	scakf_pkg::wide_t e_q;
	logic [31:0]      pp_q;
	logic [32:0]      s_q;
	logic [24:0]      k_q;
	logic [23:0]      ratio_q;
	logic [49:0]      m2_q;
	logic [48:0]      t_q;
	logic             blend_q;
	scakf_pkg::kind_t kind_q;

	// serial units
	logic        op_run_q;
	logic [5:0]  cnt_q;
	logic [65:0] prod_q;
	logic [33:0] mul_a_q;
	logic [54:0] rem_q;
	logic [53:0] den_q;
	logic [24:0] quo_q;
	scakf_pkg::wide_t        wr_a_q;
	logic [35:0]             wr_d_q;
	logic [35:0]             wr_sub_q;
	scakf_pkg::wrap_mode_t   wr_mode_q;

	// output register
	logic               result_valid_q;
	logic signed [31:0] res_angle_q;
	logic [31:0]        res_var_q;
	scakf_pkg::kind_t   res_kind_q;

	// combinational datapath
	scakf_pkg::wide_t z_w;
	scakf_pkg::wide_t x_w;
	scakf_pkg::wide_t xdu;
	scakf_pkg::wide_t e_d;
	scakf_pkg::wide_t m_d;
	scakf_pkg::wide_t e_abs;
	scakf_pkg::wide_t ke;
	scakf_pkg::wide_t xk;
	scakf_pkg::wide_t rd;
	scakf_pkg::wide_t wrap_res;
	logic [32:0] psum;
	logic [31:0] pp_d;
	logic [32:0] s_d;
	logic        small_d;
	logic [27:0] u_abs;
	logic [53:0] m2x10;
	logic [52:0] t9;
	logic [41:0] prod_rnd;
	logic        res_load;

	logic        is_mul;
	logic        is_div;
	logic        is_wrap;
	logic [5:0]  op_len;
	logic        op_fin;
	logic        op_start;
	logic        gain_skip;
	logic        gain_top;
	logic [32:0] gain_rem;

	// operands loaded into a unit at start
	logic [33:0] op_a;
	logic [31:0] op_b;
	logic [54:0] op_rem;
	logic [53:0] op_den;
	logic [24:0] op_quo;
	scakf_pkg::wide_t      op_wa;
	scakf_pkg::wrap_mode_t wr_mode_d;
	logic [35:0]           wr_d_d;

	// unit step logic
	logic [34:0] mul_sum;
	logic [54:0] rem_sh;
	logic        rem_ge;

	assign z_w   = {{11{z_q[24]}}, z_q};
	assign x_w   = {{4{est_x_q[31]}}, est_x_q};
	assign xdu   = x_w + du_q;
	assign psum  = {1'b0, est_p_q} + {1'b0, pnoise_q};
	assign pp_d  = psum[32] ? 32'hffff_ffff : psum[31:0];
	assign s_d   = {1'b0, pp_d} + {1'b0, mnoise_q};
	assign e_d   = z_w - xdu;
	assign m_d   = e_d[35] ? -e_d : e_d;
	assign small_d = (m_d[35:25] == 11'd0);
	assign e_abs = e_q[35] ? -e_q : e_q;
	assign u_abs = u_q[27] ? 28'(-u_q) : 28'(u_q);
	assign m2x10 = {1'b0, m2_q, 3'b000} + {3'b000, m2_q, 1'b0};
	assign t9    = {1'b0, t_q, 3'b000} + {4'b0000, t_q};
	assign prod_rnd = scakf_pkg::rnd24(prod_q);
	assign ke    = scakf_pkg::neg_if(e_q[35], prod_rnd);
	assign xk    = xp_q + ke;
	assign rd    = scakf_pkg::neg_if(e_q[35], prod_rnd);

	// result handover when the output register is free or being taken
	assign res_load = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	// wrap result from the reduced distance past the nearest bound
	always_comb begin
		case (wr_mode_q)
			scakf_pkg::WRAP_HIGH: begin
				wrap_res = (wr_d_q == 36'd0) ? scakf_pkg::DEG180
					: $signed(wr_d_q) - scakf_pkg::DEG180;
			end
			scakf_pkg::WRAP_LOW: begin
				wrap_res = (wr_d_q == 36'd0) ? -scakf_pkg::DEG180
					: scakf_pkg::DEG180 - $signed(wr_d_q);
			end
			default: begin
				wrap_res = wr_a_q;
			end
		endcase
	end

	// which unit a state uses
	always_comb begin
		is_mul  = 1'b0;
		is_div  = 1'b0;
		is_wrap = 1'b0;
		unique case (state_q)
			ST_DU, ST_KE, ST_M2, ST_CHI, ST_RD, ST_SHRINK: is_mul = 1'b1;
			ST_GAIN, ST_RATIO: is_div = 1'b1;
			ST_RST_WRAP, ST_PRD_WRAP, ST_WRAP_X, ST_WRAP_E, ST_WRAP_F: is_wrap = 1'b1;
			default: is_mul = 1'b0;
		endcase
	end

	assign op_len    = is_mul ? scakf_pkg::MUL_STEPS
		: (is_div ? scakf_pkg::DIV_STEPS : scakf_pkg::WRAP_STEPS);
	assign op_fin    = op_run_q && (cnt_q == op_len);
	assign gain_skip = (state_q == ST_GAIN) && (s_q == 33'd0);
	assign op_start  = (is_mul || is_div || is_wrap) && !op_run_q && !gain_skip;

	// gain: top quotient bit set only when P+R equals P
	assign gain_top = ({1'b0, pp_q} >= s_q);
	assign gain_rem = {1'b0, pp_q} - (gain_top ? s_q : 33'd0);

	// operands per state
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_rem = '0;
		op_den = '0;
		op_quo = '0;
		op_wa  = '0;
		case (state_q)
			ST_DU: begin
				op_a = {6'd0, u_abs};
				op_b = {8'd0, dt_q};
			end
			ST_KE: begin
				op_a = e_abs[33:0];
				op_b = {7'd0, k_q};
			end
			ST_M2: begin
				op_a = e_abs[33:0];
				op_b = e_abs[31:0];
			end
			ST_CHI: begin
				op_a = {1'b0, s_q};
				op_b = {16'd0, chi_q};
			end
			ST_RD: begin
				op_a = e_abs[33:0];
				op_b = {8'd0, ratio_q};
			end
			ST_SHRINK: begin
				op_a = {2'b00, pp_q};
				op_b = {7'd0, 25'(scakf_pkg::ONE_Q24) - k_q};
			end
			ST_GAIN: begin
				op_rem = {22'd0, gain_rem};
				op_den = {21'd0, s_q};
				op_quo = {24'd0, gain_top};
			end
			ST_RATIO: begin
				op_rem = {1'b0, m2x10 - {5'd0, t_q}};
				op_den = {1'b0, t9};
			end
			ST_RST_WRAP: op_wa = z_w;
			ST_PRD_WRAP, ST_WRAP_X: op_wa = xdu;
			ST_WRAP_E: op_wa = z_w - xp_q;
			ST_WRAP_F: op_wa = xp_q;
			default: op_wa = '0;
		endcase
	end

	always_comb begin
		if (op_wa < -scakf_pkg::DEG180) begin
			wr_mode_d = scakf_pkg::WRAP_LOW;
			wr_d_d    = 36'(-scakf_pkg::DEG180 - op_wa);
		end else if (op_wa > scakf_pkg::DEG180) begin
			wr_mode_d = scakf_pkg::WRAP_HIGH;
			wr_d_d    = 36'(op_wa - scakf_pkg::DEG180);
		end else begin
			wr_mode_d = scakf_pkg::WRAP_PASS;
			wr_d_d    = '0;
		end
	end

	assign mul_sum = {1'b0, prod_q[65:32]} + (prod_q[0] ? {1'b0, mul_a_q} : 35'd0);
	assign rem_sh  = {rem_q[53:0], 1'b0};
	assign rem_ge  = (rem_sh >= {1'b0, den_q});

	// serial units: one multiplier bit, one quotient bit or one wrap step a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op_start) begin
			cnt_q <= '0;
		end else if (op_run_q && !op_fin) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (op_start) begin
			mul_a_q   <= op_a;
			prod_q    <= {34'd0, op_b};
			rem_q     <= op_rem;
			den_q     <= op_den;
			quo_q     <= op_quo;
			wr_a_q    <= op_wa;
			wr_mode_q <= wr_mode_d;
			wr_d_q    <= wr_d_d;
			wr_sub_q  <= scakf_pkg::DEG360_TOP;
		end else if (op_run_q && !op_fin) begin
			if (is_mul) begin
				prod_q <= {mul_sum, prod_q[31:1]};
			end
			if (is_div) begin
				rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[23:0], rem_ge};
			end
			if (is_wrap) begin
				if (wr_d_q >= wr_sub_q) begin
					wr_d_q <= wr_d_q - wr_sub_q;
				end
				wr_sub_q <= {1'b0, wr_sub_q[35:1]};
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnoise_q   <= '0;
			mnoise_q   <= scakf_pkg::RST_MEASURE_NOISE;
			dt_q       <= scakf_pkg::RST_SAMPLE_PERIOD;
			chi_q      <= scakf_pkg::RST_CHI_THRESHOLD;
			adaptive_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scakf_pkg::REG_PROCESS_NOISE: pnoise_q   <= cfg_data;
				scakf_pkg::REG_MEASURE_NOISE: mnoise_q   <= cfg_data;
				scakf_pkg::REG_SAMPLE_PERIOD: dt_q       <= cfg_data[23:0];
				scakf_pkg::REG_CHI_THRESHOLD: chi_q      <= cfg_data[15:0];
				scakf_pkg::REG_ADAPTIVE_MODE: adaptive_q <= cfg_data[0];
				default: adaptive_q <= adaptive_q;
			endcase
		end
	end

	// payload of one word, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			req_q <= req_type;
			z_q   <= angle_value;
			zv_q  <= angle_valid;
			uv_q  <= rate_valid;
			// an invalid rate counts as zero
			u_q   <= rate_valid ? rate_value : 28'sd0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_run_q       <= 1'b0;
			est_x_q        <= '0;
			est_p_q        <= scakf_pkg::ONE_Q24;
			seeded_q       <= 1'b0;
			result_valid_q <= 1'b0;
			res_angle_q    <= '0;
			res_var_q      <= '0;
			res_kind_q     <= scakf_pkg::KIND_SEEDED;
			du_q           <= '0;
			xp_q           <= '0;
			e_q            <= '0;
			pp_q           <= '0;
			s_q            <= '0;
			k_q            <= '0;
			ratio_q        <= '0;
			m2_q           <= '0;
			t_q            <= '0;
			blend_q        <= 1'b0;
			kind_q         <= scakf_pkg::KIND_SEEDED;
		end else begin
			if (op_start) begin
				op_run_q <= 1'b1;
			end else if (op_fin) begin
				op_run_q <= 1'b0;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_DU;
					end
				end
				ST_DU: begin
					if (op_fin) begin
						du_q    <= scakf_pkg::neg_if(u_q[27], prod_rnd);
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (req_q) begin
						state_q <= ST_RST_WRAP;
					end else if (!seeded_q && zv_q) begin
						// first measurement seeds the estimate as given
						est_x_q  <= {{7{z_q[24]}}, z_q};
						seeded_q <= 1'b1;
						kind_q   <= scakf_pkg::KIND_SEEDED;
						state_q  <= ST_DONE;
					end else if (!zv_q) begin
						est_p_q <= pp_d;
						kind_q  <= scakf_pkg::KIND_PREDICT;
						if (adaptive_q) begin
							est_x_q <= scakf_pkg::sat32(xdu);
							state_q <= ST_DONE;
						end else if (uv_q) begin
							state_q <= ST_PRD_WRAP;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (!adaptive_q) begin
						pp_q    <= pp_d;
						s_q     <= s_d;
						kind_q  <= scakf_pkg::KIND_FUSED;
						state_q <= ST_WRAP_X;
					end else begin
						pp_q <= pp_d;
						s_q  <= s_d;
						xp_q <= xdu;
						e_q  <= e_d;
						if (!small_d || s_d == 33'd0) begin
							est_x_q <= {{7{z_q[24]}}, z_q};
							est_p_q <= mnoise_q;
							kind_q  <= scakf_pkg::KIND_TAKEOVER;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_M2;
						end
					end
				end
				ST_RST_WRAP: begin
					if (op_fin) begin
						est_x_q  <= wrap_res[31:0];
						est_p_q  <= scakf_pkg::ONE_Q24;
						seeded_q <= 1'b1;
						kind_q   <= scakf_pkg::KIND_RESET;
						state_q  <= ST_DONE;
					end
				end
				ST_PRD_WRAP: begin
					if (op_fin) begin
						est_x_q <= wrap_res[31:0];
						state_q <= ST_DONE;
					end
				end
				ST_WRAP_X: begin
					if (op_fin) begin
						xp_q    <= wrap_res;
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					// zero P+R gives a zero gain
					if (gain_skip || op_fin) begin
						k_q     <= gain_skip ? 25'd0 : quo_q;
						state_q <= adaptive_q ? ST_KE : ST_WRAP_E;
					end
				end
				ST_WRAP_E: begin
					if (op_fin) begin
						e_q     <= wrap_res;
						state_q <= ST_KE;
					end
				end
				ST_KE: begin
					if (op_fin) begin
						if (!adaptive_q) begin
							xp_q    <= xk;
							state_q <= ST_WRAP_F;
						end else if (!blend_q) begin
							est_x_q <= scakf_pkg::sat32(xk);
							state_q <= ST_SHRINK;
						end else begin
							// blend pulls the corrected estimate further toward z
							xp_q    <= xk;
							e_q     <= z_w - xk;
							state_q <= ST_RATIO;
						end
					end
				end
				ST_WRAP_F: begin
					if (op_fin) begin
						est_x_q <= wrap_res[31:0];
						state_q <= ST_SHRINK;
					end
				end
				ST_M2: begin
					if (op_fin) begin
						m2_q    <= prod_q[49:0];
						state_q <= ST_CHI;
					end
				end
				ST_CHI: begin
					if (op_fin) begin
						t_q     <= prod_q[48:0];
						state_q <= ST_GATE;
					end
				end
				ST_GATE: begin
					// score against chi/10 and chi, both scaled by P+Q+R
					if (m2x10 < {5'd0, t_q}) begin
						blend_q <= 1'b0;
						kind_q  <= scakf_pkg::KIND_FUSED;
						state_q <= ST_GAIN;
					end else if ({4'd0, m2_q} < {5'd0, t_q}) begin
						blend_q <= 1'b1;
						kind_q  <= scakf_pkg::KIND_BLENDED;
						state_q <= ST_GAIN;
					end else begin
						est_x_q <= {{7{z_q[24]}}, z_q};
						est_p_q <= mnoise_q;
						kind_q  <= scakf_pkg::KIND_TAKEOVER;
						state_q <= ST_DONE;
					end
				end
				ST_RATIO: begin
					if (op_fin) begin
						ratio_q <= quo_q[23:0];
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (op_fin) begin
						est_x_q <= scakf_pkg::sat32(xp_q + rd);
						state_q <= ST_SHRINK;
					end
				end
				ST_SHRINK: begin
					if (op_fin) begin
						est_p_q <= prod_rnd[31:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hand the word over once the output register is free
					if (res_load) begin
						res_angle_q    <= est_x_q;
						res_var_q      <= est_p_q;
						res_kind_q     <= kind_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall        = (state_q != ST_IDLE);
	assign result_valid      = result_valid_q;
	assign angle_estimate    = res_angle_q;
	assign variance_estimate = res_var_q;
	assign step_kind         = res_kind_q;

	// an accepted word always starts with the rate product
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && item_valid) |=> (state_q == ST_DU))
		else $error("accepted word did not start the rate product");

	// once seeded the filter stays seeded until reset
	a_seeded_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seeded_q))
		else $error("seeded flag dropped");

	// standard fusion and reset results lie within plus or minus 180 degrees
	a_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(result_valid_q) && !adaptive_q
			&& (res_kind_q == scakf_pkg::KIND_FUSED || res_kind_q == scakf_pkg::KIND_RESET))
		|-> (res_angle_q <= 32'sd11796480 && res_angle_q >= -32'sd11796480))
		else $error("wrapped estimate out of range");

	// a takeover sets the variance to the measurement noise
	a_takeover_var: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(result_valid_q) && res_kind_q == scakf_pkg::KIND_TAKEOVER)
		|-> (res_var_q == mnoise_q))
		else $error("takeover variance differs from measurement noise");

endmodule

// File: verif/scalar_angle_kalman_filter_core_tb.sv
// ----------------------------------------------------------------------------
// scalar_angle_kalman_filter_core_tb
// Self-checking bench for the scalar angle Kalman filter core. A queue of
// angle/rate words, built per register setting, feeds a clocked driver. A
// bit-accurate filter predictor computes each expected estimate on
// acceptance. A clocked monitor checks every result word, field by field.
// ----------------------------------------------------------------------------
module scalar_angle_kalman_filter_core_tb;

	// angle constants in Q16.16 degrees
	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint FULL_TURN = 64'sd23592960;
	localparam longint UNIT_Q24  = 64'sd16777216;
	localparam longint SAT_HI    = 64'sd2147483647;
	localparam longint SAT_LO    = -64'sd2147483648;
	localparam int     STALL_LIMIT = 40000;
	localparam int     DRAIN_WAIT  = 250;

	typedef struct {
		logic               req;
		logic signed [24:0] angle;
		logic               av;
		logic signed [27:0] rate;
		logic               rv;
	} word_t;

	typedef struct {
		logic signed [31:0] angle;
		logic [31:0]        var_q24;
		scakf_pkg::kind_t   kind;
	} estimate_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic req_type = 1'b0;
	logic signed [24:0] angle_value = '0;
	logic angle_valid = 1'b0;
	logic signed [27:0] rate_value = '0;
	logic rate_valid = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] angle_estimate;
	logic [31:0] variance_estimate;
	logic [2:0] step_kind;

	scalar_angle_kalman_filter_core dut (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// words waiting to be driven, and estimates waiting to be seen
	word_t     pending_words[$];
	estimate_t expected_estimates[$];

	// filter state and registers as the block should hold them
	longint filt_angle;
	longint filt_var;
	bit     filt_seeded;
	longint reg_q, reg_r, reg_dt, reg_chi;
	bit     reg_adaptive;

	// idle profile: 0 sender light / receiver heavy, 1 the reverse, 2 none
	int idle_profile = 0;
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int kind_seen[6];
	bit hold_req = 1'b0;

	// ------------------------------------------------------------------
	// filter arithmetic
	// ------------------------------------------------------------------
	function automatic longint round_q24(longint v);
		longint unsigned mag;
		mag = v < 0 ? longint'(-v) : longint'(v);
		mag = (mag + 64'd8388608) >> 24;
		return v < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint wrap_deg(longint a);
		longint n;
		if (a < -HALF_TURN) begin
			n = ((-HALF_TURN - a) + FULL_TURN - 1) / FULL_TURN;
			a = a + n * FULL_TURN;
		end else if (a > HALF_TURN) begin
			n = ((a - HALF_TURN) + FULL_TURN - 1) / FULL_TURN;
			a = a - n * FULL_TURN;
		end
		return a;
	endfunction

	function automatic longint clip32(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint var_plus(longint p, longint q);
		longint s;
		s = p + q;
		return s > 64'sd4294967295 ? 64'sd4294967295 : s;
	endfunction

	function automatic longint kalman_gain(longint p, longint r);
		longint s;
		s = p + r;
		if (s == 0) return 0;
		return (p << 24) / s;
	endfunction

	function automatic longint var_shrink(longint k, longint p);
		longint unsigned t;
		t = longint'(UNIT_Q24 - k) * p + 64'd8388608;
		return longint'(t >> 24);
	endfunction

	// advance the filter by one accepted word and return its estimate
	function automatic estimate_t filter_step(word_t w);
		estimate_t res;
		longint z, u, du, x, e, k, xp, pp, xk, d;
		longint unsigned s, m, t, m2, num, den, ratio;
		bit near;
		z = w.angle;
		u = w.rv ? longint'(w.rate) : 0;
		du = round_q24(u * reg_dt);
		if (w.req) begin
			filt_angle = wrap_deg(z);
			filt_var = UNIT_Q24;
			filt_seeded = 1'b1;
			res.kind = scakf_pkg::KIND_RESET;
		end else if (!filt_seeded && w.av) begin
			filt_angle = z;
			filt_seeded = 1'b1;
			res.kind = scakf_pkg::KIND_SEEDED;
		end else if (!w.av) begin
			if (reg_adaptive) filt_angle = clip32(filt_angle + du);
			else if (w.rv) filt_angle = wrap_deg(filt_angle + du);
			filt_var = var_plus(filt_var, reg_q);
			res.kind = scakf_pkg::KIND_PREDICT;
		end else if (!reg_adaptive) begin
			x = wrap_deg(filt_angle + du);
			filt_var = var_plus(filt_var, reg_q);
			k = kalman_gain(filt_var, reg_r);
			e = wrap_deg(z - x);
			filt_angle = wrap_deg(x + round_q24(k * e));
			filt_var = var_shrink(k, filt_var);
			res.kind = scakf_pkg::KIND_FUSED;
		end else begin
			xp = filt_angle + du;
			pp = var_plus(filt_var, reg_q);
			s = pp + reg_r;
			e = z - xp;
			m = e < 0 ? longint'(-e) : longint'(e);
			t = reg_chi * s;
			m2 = m * m;
			near = m < 64'd33554432;
			if (near && s != 0 && 10 * m2 < t) begin
				k = kalman_gain(pp, reg_r);
				filt_angle = clip32(xp + round_q24(k * e));
				filt_var = var_shrink(k, pp);
				res.kind = scakf_pkg::KIND_FUSED;
			end else if (near && s != 0 && m2 < t) begin
				// blend toward the measurement by a ratio set by the score
				k = kalman_gain(pp, reg_r);
				xk = xp + round_q24(k * e);
				d = z - xk;
				num = 10 * m2 - t;
				den = 9 * t;
				ratio = 0;
				for (int i = 0; i < 24; i++) begin
					num = num << 1;
					ratio = ratio << 1;
					if (num >= den) begin
						num = num - den;
						ratio = ratio | 1;
					end
				end
				filt_angle = clip32(xk + round_q24(longint'(ratio) * d));
				filt_var = var_shrink(k, pp);
				res.kind = scakf_pkg::KIND_BLENDED;
			end else begin
				// measurement takes over
				filt_angle = z;
				filt_var = reg_r;
				res.kind = scakf_pkg::KIND_TAKEOVER;
			end
		end
		res.angle = filt_angle[31:0];
		res.var_q24 = filt_var[31:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// driver: offers queued words, predicts each one as it is taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic next_valid;
		int idle_pct;
		word_t w;
		if (arst_n) begin
			next_valid = item_valid;
			if (item_valid && !item_stall) begin
				w.req = req_type;
				w.angle = angle_value;
				w.av = angle_valid;
				w.rate = rate_value;
				w.rv = rate_valid;
				expected_estimates.push_back(filter_step(w));
				words_in++;
				next_valid = 1'b0;
			end
			// a stalled word stays put, otherwise maybe load the next one
			if (!(item_valid && item_stall)) begin
				idle_pct = idle_profile == 0 ? 24 : (idle_profile == 1 ? 78 : 0);
				if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
					w = pending_words.pop_front();
					req_type <= w.req;
					angle_value <= w.angle;
					angle_valid <= w.av;
					rate_value <= w.rate;
					rate_valid <= w.rv;
					next_valid = 1'b1;
				end
			end
			item_valid <= next_valid;
		end
	end

	// receiver stall, with one long hold-off to fill the block up
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		int stall_pct;
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 3000;
			end
			stall_pct = idle_profile == 0 ? 78 : (idle_profile == 1 ? 24 : 0);
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= $urandom_range(99) < stall_pct;
			end
		end
	end

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("mismatch on result word %0d: %s got %0d, expected %0d",
			words_out, field, got, want);
	endtask

	// ------------------------------------------------------------------
	// monitor: every taken result word against the oldest estimate
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_estimates.size() == 0) begin
				report_mismatch("unexpected result word, step_kind", step_kind, -1);
			end else begin
				want = expected_estimates.pop_front();
				if (angle_estimate !== want.angle)
					report_mismatch("angle_estimate", angle_estimate, want.angle);
				if (variance_estimate !== want.var_q24)
					report_mismatch("variance_estimate", variance_estimate, want.var_q24);
				if (step_kind !== want.kind)
					report_mismatch("step_kind", step_kind, want.kind);
				if (want.kind <= scakf_pkg::KIND_RESET) kind_seen[want.kind]++;
			end
			words_out++;
		end
	end

	// watchdog on cycles with no word moving on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_word(bit req, longint ang, bit av, longint rate, bit rv);
		word_t w;
		w.req = req;
		w.angle = ang[24:0];
		w.av = av;
		w.rate = rate[27:0];
		w.rv = rv;
		pending_words.push_back(w);
	endtask

	// write one register at a clock edge and track it in the predictor
	task automatic write_reg(scakf_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			scakf_pkg::REG_PROCESS_NOISE: reg_q = val;
			scakf_pkg::REG_MEASURE_NOISE: reg_r = val;
			scakf_pkg::REG_SAMPLE_PERIOD: reg_dt = val[23:0];
			scakf_pkg::REG_CHI_THRESHOLD: reg_chi = val[15:0];
			scakf_pkg::REG_ADAPTIVE_MODE: reg_adaptive = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [31:0] q, logic [31:0] r, logic [31:0] dt,
			logic [31:0] chi, bit adaptive);
		write_reg(scakf_pkg::REG_PROCESS_NOISE, q);
		write_reg(scakf_pkg::REG_MEASURE_NOISE, r);
		write_reg(scakf_pkg::REG_SAMPLE_PERIOD, dt);
		write_reg(scakf_pkg::REG_CHI_THRESHOLD, chi);
		write_reg(scakf_pkg::REG_ADAPTIVE_MODE, adaptive);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every word is taken and answered, then let the core settle
	task automatic wait_drained();
		while (pending_words.size() != 0 || item_valid || expected_estimates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// a tracked trajectory: measurements around a moving true angle with
	// noise of mixed size, plus reset words and fully random noise words
	task automatic queue_track(int n);
		longint truth, spin, noise, z;
		int pick, scale;
		truth = longint'($urandom_range(23592960)) - HALF_TURN;
		spin = longint'($urandom_range(13107200)) - 64'sd6553600;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				queue_word(1'b1, $urandom(), $urandom_range(1), $urandom(), $urandom_range(1));
			end else if (pick < 10) begin
				queue_word(1'b0, $urandom(), $urandom_range(1), $urandom(), $urandom_range(1));
			end else begin
				spin = spin + longint'($urandom_range(131072)) - 64'sd65536;
				truth = wrap_deg(truth + spin / 1000);
				case ($urandom_range(4))
					0: scale = 0;
					1: scale = 8;
					2: scale = 14;
					3: scale = 18;
					default: scale = 22;
				endcase
				noise = longint'($urandom_range(32'd1 << scale)) - (longint'(1) << (scale - 1 < 0 ? 0 : scale - 1));
				if (scale == 0) noise = 0;
				z = truth + noise;
				queue_word(1'b0, z, $urandom_range(99) < 90, spin, $urandom_range(99) < 90);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		filt_angle = 0;
		filt_var = UNIT_Q24;
		filt_seeded = 1'b0;
		reg_q = 0;
		reg_r = scakf_pkg::RST_MEASURE_NOISE;
		reg_dt = scakf_pkg::RST_SAMPLE_PERIOD;
		reg_chi = scakf_pkg::RST_CHI_THRESHOLD;
		reg_adaptive = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed, standard mode at reset settings
		queue_word(1'b0, 1000, 1'b0, 6553600, 1'b1);     // predict before seeding
		queue_word(1'b0, 1000, 1'b0, 6553600, 1'b0);     // same, rate invalid
		queue_word(1'b0, 16777215, 1'b1, 0, 1'b1);       // seed, unwrapped large angle
		queue_word(1'b0, -11796480, 1'b1, 134217727, 1'b1);
		queue_word(1'b0, 11796480, 1'b1, -134217728, 1'b1);
		queue_word(1'b0, -16777216, 1'b1, 0, 1'b0);
		queue_word(1'b0, 0, 1'b0, 131072000, 1'b1);      // predict only, wraps
		queue_word(1'b0, 0, 1'b0, -131072000, 1'b0);     // predict, x untouched
		queue_word(1'b1, 16777215, 1'b1, 134217727, 1'b1); // reset, wraps down
		queue_word(1'b1, -16777216, 1'b0, 0, 1'b0);      // reset, wraps up
		queue_word(1'b1, 11796480, 1'b1, 0, 1'b1);
		queue_word(1'b0, -11796480, 1'b1, 65536, 1'b1);
		wait_drained();

		// adaptive directed: close, mid-distance and far measurements
		set_regs(32'd1677, 32'd167772, 32'd16777, 32'd983, 1'b1);
		queue_word(1'b1, 0, 1'b1, 0, 1'b1);
		queue_word(1'b0, 100, 1'b1, 0, 1'b1);
		queue_word(1'b0, 40000, 1'b1, 0, 1'b1);
		queue_word(1'b0, 20000, 1'b1, 0, 1'b1);
		queue_word(1'b0, 11796480, 1'b1, 134217727, 1'b1);
		queue_word(1'b0, 0, 1'b0, 134217727, 1'b1);
		queue_word(1'b0, 0, 1'b0, 0, 1'b0);
		queue_word(1'b0, -16777216, 1'b1, -134217728, 1'b1);
		wait_drained();

		// random phases across settings and idle profiles
		for (int ph = 0; ph < 7; ph++) begin
			idle_profile = ph < 2 ? 0 : (ph < 4 ? 1 : 2);
			case (ph)
				0: set_regs(32'd0, 32'd6711, 32'd33554, 32'd983, 1'b0);
				1: set_regs(32'd1677, 32'd167772, 32'd16777, 32'd983, 1'b1);
				2: set_regs(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
				3: set_regs(32'hffffffff, 32'hffffffff, 32'hffffff, 32'hffff, 1'b0);
				4: set_regs(32'hffffffff, 32'hffffffff, 32'hffffff, 32'hffff, 1'b1);
				5: set_regs($urandom_range(32'h100000), $urandom_range(32'h1000000),
					$urandom_range(32'hffffff), $urandom_range(16'hffff), 1'b0);
				default: set_regs($urandom_range(32'h10000), $urandom_range(32'h100000),
					$urandom_range(32'h40000), $urandom_range(2000, 100), 1'b1);
			endcase
			if (ph == 1) hold_req = 1'b1;
			queue_track(235);
			wait_drained();
		end

		$display("covered %0d words in, %0d results out over standard and adaptive settings",
			words_in, words_out);
		$display("kinds seen: seeded %0d predict %0d fused %0d blended %0d takeover %0d reset %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5]);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
